/* rtl/motor_gear_direction_sequencer_top_defines.svh */
// Assertion macros for the motor gear and direction sequencer.
// Included by the RTL top, which checks its own logic; no other dependencies.
`ifndef MOTOR_GEAR_DIRECTION_SEQUENCER_TOP_DEFINES_SVH
`define MOTOR_GEAR_DIRECTION_SEQUENCER_TOP_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define MGDS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the trigger.
`define MGDS_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mgds_pkg.sv */
// Shared types and constants for the motor gear and direction sequencer.
// No dependencies; the RTL modules and the command and result interfaces import this package.
package mgds_pkg;

  // Highest gear magnitude accepted by a run beat
  localparam int unsigned GEAR_MAX = 3;

  typedef logic signed [4:0] gear_t;

  localparam logic [4:0] GEAR_MAG_MAX = 5'(GEAR_MAX);
  localparam gear_t GEAR_LIMIT = gear_t'(GEAR_MAX);
  localparam gear_t GEAR_LIMIT_NEG = -gear_t'(GEAR_MAX);

  // Configuration reset values
  localparam logic [15:0] DIR_DELAY_RESET = 16'd500;
  localparam logic [15:0] RESET_PULSE_RESET = 16'd200;
  localparam logic [5:0] SPEED_CODES_RESET = 6'd57;

  typedef enum logic [1:0] {
    OP_RUN         = 2'd0,
    OP_FAULT_RESET = 2'd1,
    OP_TICK        = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_RANGE      = 2'd1,
    ST_NO_REVERSE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CFG_DIR_DELAY      = 3'd0,
    CFG_RESET_PULSE    = 3'd1,
    CFG_SPEED_CODES    = 3'd2,
    CFG_SPEED_IO_EN    = 3'd3,
    CFG_REVERSE_FITTED = 3'd4
  } cfg_idx_e;

  // Output pin levels
  typedef struct packed {
    logic rst;
    logic sp2;
    logic sp1;
    logic rev;
    logic fwd;
  } pins_t;

  typedef struct packed {
    gear_t       applied;
    gear_t       pending;
    logic [15:0] dir_timer;
    logic [15:0] reset_timer;
    logic        reset_active;
    pins_t       pins;
  } state_t;

  typedef struct packed {
    logic [15:0] dir_delay;
    logic [15:0] reset_pulse;
    logic [5:0]  speed_codes;
    logic        speed_io_en;
    logic        reverse_fitted;
  } cfg_t;

  typedef struct packed {
    logic    fwd_on;
    logic    rev_on;
    logic    speed_bit_one;
    logic    speed_bit_two;
    logic    reset_on;
    status_e status;
    gear_t   gear_now;
    gear_t   gear_waiting;
  } result_t;

endpackage

/* rtl/mgds_if.sv */
// Handshake channels of the sequencer: command in, result out, config write.
// Depends on mgds_pkg for the gear type.
interface mgds_in_if;
  import mgds_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  gear_t       gear_request;
  logic [7:0]  elapsed_ms;

  modport source (output valid, output opcode, output gear_request, output elapsed_ms,
                  input ready);
  modport sink (input valid, input opcode, input gear_request, input elapsed_ms,
                output ready);
endinterface

interface mgds_out_if;
  import mgds_pkg::*;
  logic        valid;
  logic        ready;
  logic        fwd_on;
  logic        rev_on;
  logic        speed_bit_one;
  logic        speed_bit_two;
  logic        reset_on;
  logic [1:0]  status;
  gear_t       gear_now;
  gear_t       gear_waiting;

  modport source (output valid, output fwd_on, output rev_on, output speed_bit_one,
                  output speed_bit_two, output reset_on, output status,
                  output gear_now, output gear_waiting, input ready);
  modport sink (input valid, input fwd_on, input rev_on, input speed_bit_one,
                input speed_bit_two, input reset_on, input status,
                input gear_now, input gear_waiting, output ready);
endinterface

interface mgds_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/motor_gear_direction_sequencer_top.sv */
// Top level of the motor gear and direction sequencer: state and config registers.
// Depends on mgds_pkg, mgds_if, mgds_step, mgds_outq and the assertion macros.
//
//   channel  dir  handshake          payload
//   in_i     in   valid / ready      opcode, gear_request, elapsed_ms
//   out_o    out  valid / ready      fwd_on .. reset_on, status, gear_now, gear_waiting
//   cfg_i    in   valid / ready      index, data
//
// One command beat per cycle while in_i.ready is high; its result leaves the queue
// the next cycle at the earliest. The state update is one pass through mgds_step,
// registered on accept. The two-entry result queue lets two results wait before
// in_i.ready drops. cfg_i is always ready; a write takes effect at the next clock edge.
// Reset restores the configuration defaults and stops all outputs.
`include "motor_gear_direction_sequencer_top_defines.svh"

module motor_gear_direction_sequencer_top
  import mgds_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mgds_in_if.sink     in_i,
  mgds_out_if.source  out_o,
  mgds_cfg_if.sink    cfg_i
);

  state_t  state_q;
  state_t  state_d;
  state_t  step_state;
  result_t step_result;
  cfg_t    cfg_q;
  cfg_t    cfg_d;
  logic    q_full;
  logic    in_acc;
  logic    cfg_acc;

  assign in_i.ready = ~q_full;
  assign cfg_i.ready = 1'b1;
  assign in_acc = in_i.valid & in_i.ready;
  assign cfg_acc = cfg_i.valid & cfg_i.ready;

  mgds_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .opcode_i (in_i.opcode),
    .gear_i   (in_i.gear_request),
    .elapsed_i(in_i.elapsed_ms),
    .state_o  (step_state),
    .result_o (step_result)
  );

  mgds_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_acc),
    .data_i (step_result),
    .full_o (q_full),
    .out_o  (out_o)
  );

  // Config writes; speed register writes drop both speed levels
  always_comb begin
    cfg_d = cfg_q;
    state_d = in_acc ? step_state : state_q;
    if (cfg_acc) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_DIR_DELAY: cfg_d.dir_delay = cfg_i.data;
        CFG_RESET_PULSE: cfg_d.reset_pulse = cfg_i.data;
        CFG_SPEED_CODES: begin
          cfg_d.speed_codes = cfg_i.data[5:0];
          state_d.pins.sp1 = 1'b0;
          state_d.pins.sp2 = 1'b0;
        end
        CFG_SPEED_IO_EN: begin
          cfg_d.speed_io_en = cfg_i.data[0];
          state_d.pins.sp1 = 1'b0;
          state_d.pins.sp2 = 1'b0;
        end
        CFG_REVERSE_FITTED: cfg_d.reverse_fitted = cfg_i.data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dir_delay <= DIR_DELAY_RESET;
      cfg_q.reset_pulse <= RESET_PULSE_RESET;
      cfg_q.speed_codes <= SPEED_CODES_RESET;
      cfg_q.speed_io_en <= 1'b0;
      cfg_q.reverse_fitted <= 1'b1;
      state_q <= '0;
    end else begin
      cfg_q <= cfg_d;
      state_q <= state_d;
    end
  end

  // A pending gear only exists while the run outputs are dropped
  `MGDS_ASSERT_ALWAYS(a_pending_stopped,
    state_q.pending == '0 || (!state_q.pins.fwd && !state_q.pins.rev && state_q.applied == '0),
    "pending gear while run outputs are driven")
  // Reset pin follows the pulse tracker
  `MGDS_ASSERT_ALWAYS(a_reset_pin_tracks,
    state_q.pins.rst == state_q.reset_active, "reset pin out of step with pulse state")
  // Applied gear stays within range
  `MGDS_ASSERT_ALWAYS(a_gear_in_range,
    state_q.applied <= GEAR_LIMIT && state_q.applied >= GEAR_LIMIT_NEG,
    "applied gear out of range")
  // Every accepted command beat yields a waiting result
  `MGDS_ASSERT_NEXT(a_result_follows, in_acc, out_o.valid,
    "no result after an accepted command")

endmodule

/* rtl/mgds_step.sv */
// Next-state and result logic for one command beat of the sequencer.
// Purely combinational; depends on mgds_pkg.
module mgds_step
  import mgds_pkg::*;
(
  input  state_t      state_i,
  input  cfg_t        cfg_i,
  input  logic [1:0]  opcode_i,
  input  gear_t       gear_i,
  input  logic [7:0]  elapsed_i,
  output state_t      state_o,
  output result_t     result_o
);

  // Magnitude of a gear, 16 fits in five unsigned bits
  function automatic logic [4:0] gear_mag(gear_t g);
    return g[4] ? 5'(-g) : 5'(g);
  endfunction

  // Speed code for a gear magnitude, zero where the code lies above the field
  function automatic logic [1:0] speed_code(logic [4:0] mag, logic [5:0] codes);
    logic [5:0] sh;
    logic [5:0] shifted;
    sh = {mag - 5'd1, 1'b0};
    shifted = codes >> sh;
    return (sh < 6'd6) ? shifted[1:0] : 2'b00;
  endfunction

  // Drop run outputs; speed levels only when the speed pins are driven
  function automatic pins_t drop_pins(pins_t p, cfg_t c);
    pins_t r;
    r = p;
    if (c.speed_io_en) begin
      r.sp1 = 1'b0;
      r.sp2 = 1'b0;
    end
    r.fwd = 1'b0;
    r.rev = 1'b0;
    return r;
  endfunction

  // Drive pins for a nonzero gear
  function automatic pins_t apply_pins(pins_t p, gear_t g, cfg_t c);
    pins_t      r;
    logic [4:0] mag;
    logic [1:0] code;
    r = p;
    mag = gear_mag(g);
    code = speed_code(mag, c.speed_codes);
    if (c.speed_io_en && mag >= 5'd1 && mag <= GEAR_MAG_MAX) begin
      r.sp1 = code[0];
      r.sp2 = code[1];
    end
    if (!g[4] && g != '0) begin
      r.rev = 1'b0;
      r.fwd = 1'b1;
    end else begin
      r.fwd = 1'b0;
      if (c.reverse_fitted) begin
        r.rev = 1'b1;
      end
    end
    return r;
  endfunction

  logic [16:0] dir_sum;
  logic [16:0] rst_sum;
  logic [15:0] dir_sat;
  logic [15:0] rst_sat;
  state_t      nxt;
  status_e     status;

  // Saturating timer sums for a tick
  assign dir_sum = {1'b0, state_i.dir_timer} + {9'd0, elapsed_i};
  assign rst_sum = {1'b0, state_i.reset_timer} + {9'd0, elapsed_i};
  assign dir_sat = dir_sum[16] ? 16'hFFFF : dir_sum[15:0];
  assign rst_sat = rst_sum[16] ? 16'hFFFF : rst_sum[15:0];

  // Update state for the beat
  always_comb begin
    nxt = state_i;
    status = ST_OK;
    case (opcode_i)
      OP_RUN: begin
        if (gear_mag(gear_i) > GEAR_MAG_MAX) begin
          status = ST_RANGE;
        end else if (gear_i[4] && !cfg_i.reverse_fitted) begin
          status = ST_NO_REVERSE;
        end else if (gear_i == '0) begin
          nxt.pins = drop_pins(state_i.pins, cfg_i);
          nxt.applied = '0;
          nxt.pending = '0;
        end else if (state_i.pending != '0 && state_i.pending[4] == gear_i[4]) begin
          nxt.pending = gear_i;
        end else begin
          nxt.pending = '0;
          if (state_i.applied != '0 && state_i.applied[4] != gear_i[4]) begin
            // Reversal: stop now, hold the new gear until the delay runs out
            nxt.pins = drop_pins(state_i.pins, cfg_i);
            nxt.applied = '0;
            nxt.pending = gear_i;
            nxt.dir_timer = '0;
          end else begin
            nxt.pins = apply_pins(state_i.pins, gear_i, cfg_i);
            nxt.applied = gear_i;
          end
        end
      end
      OP_FAULT_RESET: begin
        nxt.pins = drop_pins(state_i.pins, cfg_i);
        nxt.pins.rst = 1'b1;
        nxt.applied = '0;
        nxt.pending = '0;
        nxt.reset_timer = '0;
        nxt.reset_active = 1'b1;
      end
      OP_TICK: begin
        nxt.dir_timer = dir_sat;
        nxt.reset_timer = rst_sat;
        if (state_i.reset_active && rst_sat >= cfg_i.reset_pulse) begin
          nxt.pins.rst = 1'b0;
          nxt.reset_active = 1'b0;
        end
        if (state_i.pending != '0 && dir_sat >= cfg_i.dir_delay) begin
          nxt.pins = apply_pins(nxt.pins, state_i.pending, cfg_i);
          nxt.applied = state_i.pending;
          nxt.pending = '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign state_o = nxt;

  // Result shows levels after the beat
  assign result_o.fwd_on = nxt.pins.fwd;
  assign result_o.rev_on = nxt.pins.rev & cfg_i.reverse_fitted;
  assign result_o.speed_bit_one = nxt.pins.sp1;
  assign result_o.speed_bit_two = nxt.pins.sp2;
  assign result_o.reset_on = nxt.pins.rst;
  assign result_o.status = status;
  assign result_o.gear_now = nxt.applied;
  assign result_o.gear_waiting = nxt.pending;

endmodule

/* rtl/mgds_outq.sv */
// Two-entry result queue that decouples the command side from the result side.
// Depends on mgds_pkg and the mgds_out_if channel.
module mgds_outq
  import mgds_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  result_t         data_i,
  output logic            full_o,
  mgds_out_if.source      out_o
);

  result_t     mem_q [2];
  logic        wr_ptr_q;
  logic        wr_ptr_d;
  logic        rd_ptr_q;
  logic        rd_ptr_d;
  logic [1:0]  cnt_q;
  logic [1:0]  cnt_d;
  logic        pop;
  result_t     head;

  assign pop = out_o.valid & out_o.ready;
  assign full_o = (cnt_q == 2'd2);

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  // Hold result beats
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign head = mem_q[rd_ptr_q];
  assign out_o.valid = (cnt_q != 2'd0);
  assign out_o.fwd_on = head.fwd_on;
  assign out_o.rev_on = head.rev_on;
  assign out_o.speed_bit_one = head.speed_bit_one;
  assign out_o.speed_bit_two = head.speed_bit_two;
  assign out_o.reset_on = head.reset_on;
  assign out_o.status = head.status;
  assign out_o.gear_now = head.gear_now;
  assign out_o.gear_waiting = head.gear_waiting;

endmodule

/* verif/mgds_result_checker.sv */
`timescale 1ns / 1ps
// Result checker for the motor gear and direction sequencer: mirrors the drive
// state and registers, forecasts every result beat and compares it on arrival.
// Depends on mgds_pkg and the channel interfaces in mgds_if.
module mgds_result_checker
  import mgds_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mgds_in_if          cmd_mon_i,
  mgds_out_if         res_mon_i,
  mgds_cfg_if         reg_mon_i,
  input  logic        end_check_i,
  output int unsigned fail_cnt_o,
  output int unsigned result_cnt_o
);

  // Mirrored registers
  logic [15:0] dir_delay_ms;
  logic [15:0] reset_pulse_ms;
  logic [5:0]  speed_codes;
  logic        speed_io_en;
  logic        reverse_fitted;

  // Mirrored drive state
  gear_t       applied_gear;
  gear_t       wait_gear;
  logic [15:0] dir_ms;
  logic [15:0] pulse_ms;
  logic        pulse_active;
  pins_t       pins;

  result_t     pin_forecast_q[$];
  int unsigned fails;
  int unsigned results;
  bit          end_checked;

  // Add elapsed milliseconds, sticking at full scale
  function automatic logic [15:0] add_ms_saturating(logic [15:0] acc, logic [7:0] step_ms);
    logic [16:0] sum;
    sum = {1'b0, acc} + {9'd0, step_ms};
    return sum[16] ? 16'hFFFF : sum[15:0];
  endfunction

  // Drop the run levels; touch the speed levels only when the speed pins are driven
  task automatic drop_run_outputs();
    if (speed_io_en) begin
      pins.sp1 = 1'b0;
      pins.sp2 = 1'b0;
    end
    pins.fwd = 1'b0;
    pins.rev = 1'b0;
    applied_gear = '0;
  endtask

  // Put a gear on the pins: speed code by magnitude, direction by sign
  task automatic engage_gear(input gear_t gear);
    int         g;
    int         mag;
    logic [1:0] code;
    g = gear;
    mag = (g < 0) ? -g : g;
    if (speed_io_en && mag >= 1 && mag <= int'(GEAR_MAX)) begin
      code = speed_codes[2*(mag-1) +: 2];
      pins.sp1 = code[0];
      pins.sp2 = code[1];
    end
    if (g > 0) begin
      pins.rev = 1'b0;
      pins.fwd = 1'b1;
    end else begin
      pins.fwd = 1'b0;
      if (reverse_fitted) pins.rev = 1'b1;
    end
    applied_gear = gear;
  endtask

  // Advance the mirrored state by one command beat and forecast its result
  task automatic advance_drive_state(input logic [1:0] op, input gear_t gear_req,
                                     input logic [7:0] step_ms, output result_t fc);
    int      g;
    int      mag;
    status_e st;
    g = gear_req;
    mag = (g < 0) ? -g : g;
    st = ST_OK;
    case (op)
      OP_RUN: begin
        if (mag > int'(GEAR_MAX)) begin
          st = ST_RANGE;
        end else if (g < 0 && !reverse_fitted) begin
          st = ST_NO_REVERSE;
        end else if (g == 0) begin
          drop_run_outputs();
          wait_gear = '0;
        end else if (wait_gear != 0 && ((wait_gear > 0) == (g > 0))) begin
          // same direction as the waiting gear: swap it, keep the timer running
          wait_gear = gear_req;
        end else begin
          wait_gear = '0;
          if (applied_gear != 0 && ((applied_gear > 0) != (g > 0))) begin
            // reversal while running: stop now, apply after the delay
            drop_run_outputs();
            wait_gear = gear_req;
            dir_ms = '0;
          end else begin
            engage_gear(gear_req);
          end
        end
      end
      OP_FAULT_RESET: begin
        drop_run_outputs();
        wait_gear = '0;
        pins.rst = 1'b1;
        pulse_ms = '0;
        pulse_active = 1'b1;
      end
      OP_TICK: begin
        dir_ms = add_ms_saturating(dir_ms, step_ms);
        pulse_ms = add_ms_saturating(pulse_ms, step_ms);
        if (pulse_active && pulse_ms >= reset_pulse_ms) begin
          pins.rst = 1'b0;
          pulse_active = 1'b0;
        end
        if (wait_gear != 0 && dir_ms >= dir_delay_ms) begin
          engage_gear(wait_gear);
          wait_gear = '0;
        end
      end
      default: ;
    endcase
    fc.fwd_on        = pins.fwd;
    fc.rev_on        = pins.rev & reverse_fitted;
    fc.speed_bit_one = pins.sp1;
    fc.speed_bit_two = pins.sp2;
    fc.reset_on      = pins.rst;
    fc.status        = st;
    fc.gear_now      = applied_gear;
    fc.gear_waiting  = wait_gear;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_beats
    result_t fc;
    result_t got;
    string   diffs;
    if (!rst_ni) begin
      dir_delay_ms   = DIR_DELAY_RESET;
      reset_pulse_ms = RESET_PULSE_RESET;
      speed_codes    = SPEED_CODES_RESET;
      speed_io_en    = 1'b0;
      reverse_fitted = 1'b1;
      applied_gear   = '0;
      wait_gear      = '0;
      dir_ms         = '0;
      pulse_ms       = '0;
      pulse_active   = 1'b0;
      pins           = '0;
      pin_forecast_q.delete();
      fails          = 0;
      results        = 0;
      end_checked    = 1'b0;
    end else begin
      // Mirror register writes; speed code or enable changes drop the speed levels
      if (reg_mon_i.valid && reg_mon_i.ready) begin
        case (reg_mon_i.index)
          CFG_DIR_DELAY:   dir_delay_ms = reg_mon_i.data;
          CFG_RESET_PULSE: reset_pulse_ms = reg_mon_i.data;
          CFG_SPEED_CODES: begin
            speed_codes = reg_mon_i.data[5:0];
            pins.sp1 = 1'b0;
            pins.sp2 = 1'b0;
          end
          CFG_SPEED_IO_EN: begin
            speed_io_en = reg_mon_i.data[0];
            pins.sp1 = 1'b0;
            pins.sp2 = 1'b0;
          end
          CFG_REVERSE_FITTED: reverse_fitted = reg_mon_i.data[0];
          default: ;
        endcase
      end

      // Forecast the result of each accepted command beat
      if (cmd_mon_i.valid && cmd_mon_i.ready) begin
        advance_drive_state(cmd_mon_i.opcode, cmd_mon_i.gear_request,
                            cmd_mon_i.elapsed_ms, fc);
        pin_forecast_q.push_back(fc);
      end

      // Compare each result beat with the oldest forecast
      if (res_mon_i.valid && res_mon_i.ready) begin
        results++;
        got.fwd_on        = res_mon_i.fwd_on;
        got.rev_on        = res_mon_i.rev_on;
        got.speed_bit_one = res_mon_i.speed_bit_one;
        got.speed_bit_two = res_mon_i.speed_bit_two;
        got.reset_on      = res_mon_i.reset_on;
        got.status        = status_e'(res_mon_i.status);
        got.gear_now      = res_mon_i.gear_now;
        got.gear_waiting  = res_mon_i.gear_waiting;
        if (pin_forecast_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("%0t: result beat %0d arrived with nothing forecast",
                                    $time, results);
        end else begin
          fc = pin_forecast_q.pop_front();
          diffs = "";
          if (got.fwd_on !== fc.fwd_on) diffs = {diffs, " fwd_on"};
          if (got.rev_on !== fc.rev_on) diffs = {diffs, " rev_on"};
          if (got.speed_bit_one !== fc.speed_bit_one) diffs = {diffs, " speed_bit_one"};
          if (got.speed_bit_two !== fc.speed_bit_two) diffs = {diffs, " speed_bit_two"};
          if (got.reset_on !== fc.reset_on) diffs = {diffs, " reset_on"};
          if (got.status !== fc.status) diffs = {diffs, " status"};
          if (got.gear_now !== fc.gear_now) diffs = {diffs, " gear_now"};
          if (got.gear_waiting !== fc.gear_waiting) diffs = {diffs, " gear_waiting"};
          if (diffs != "") begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: result beat %0d differs in%s", $time, results, diffs);
              $display("  exp fwd %0b rev %0b sp1 %0b sp2 %0b rst %0b st %0d now %0d wt %0d",
                       fc.fwd_on, fc.rev_on, fc.speed_bit_one, fc.speed_bit_two,
                       fc.reset_on, fc.status, fc.gear_now, fc.gear_waiting);
              $display("  got fwd %0b rev %0b sp1 %0b sp2 %0b rst %0b st %0d now %0d wt %0d",
                       got.fwd_on, got.rev_on, got.speed_bit_one, got.speed_bit_two,
                       got.reset_on, got.status, got.gear_now, got.gear_waiting);
            end
          end
        end
      end

      // Count forecasts that never got a result beat
      if (end_check_i && !end_checked) begin
        end_checked = 1'b1;
        if (pin_forecast_q.size() != 0) begin
          fails += pin_forecast_q.size();
          $display("%0d forecast result beats never arrived", pin_forecast_q.size());
        end
      end
    end
    fail_cnt_o   <= fails;
    result_cnt_o <= results;
  end

endmodule

/* verif/tb_motor_gear_direction_sequencer_top.sv */
`timescale 1ns / 1ps
// Testbench top for the motor gear and direction sequencer: drives command and
// register beats, paces the result side and reports the verdict.
// Depends on mgds_pkg, mgds_if, the RTL top and mgds_result_checker.
module tb_motor_gear_direction_sequencer_top;
  import mgds_pkg::*;

  localparam logic [1:0]  OP_UNUSED        = 2'd3;
  localparam int unsigned LONG_HOLD_CYCLES = 60;
  localparam int unsigned PHASE_BEATS      = 40;
  localparam int unsigned SAT_TICKS        = 262;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        end_check;
  int unsigned fail_cnt;
  int unsigned result_cnt;

  int unsigned beats_sent;
  int unsigned reg_writes;
  int unsigned settings_used;
  bit          src_gaps;
  bit          sink_stalls;
  bit          hold_sink;

  mgds_in_if  cmd_ch ();
  mgds_out_if res_ch ();
  mgds_cfg_if reg_ch ();

  motor_gear_direction_sequencer_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch),
    .out_o  (res_ch),
    .cfg_i  (reg_ch)
  );

  mgds_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_mon_i    (cmd_ch),
    .res_mon_i    (res_ch),
    .reg_mon_i    (reg_ch),
    .end_check_i  (end_check),
    .fail_cnt_o   (fail_cnt),
    .result_cnt_o (result_cnt)
  );

  always #1 clk_i = ~clk_i;

  // Offer one command beat, optionally after a short gap, and hold it until taken
  task automatic send_cmd(input logic [1:0] op, input int gear, input logic [7:0] step_ms);
    int unsigned gap;
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.opcode       <= op;
    cmd_ch.gear_request <= gear_t'(gear);
    cmd_ch.elapsed_ms   <= step_ms;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    beats_sent++;
  endtask

  // Mostly legal gears and ticks, some out-of-range gears, resets and unused opcodes
  task automatic send_random_cmd();
    int unsigned pick;
    logic [1:0]  op;
    int          gear;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) gear = int'($urandom_range(0, 31)) - 16;
    else gear = int'($urandom_range(0, 6)) - 3;
    if (pick < 50) op = OP_RUN;
    else if (pick < 85) op = OP_TICK;
    else if (pick < 94) op = OP_FAULT_RESET;
    else op = OP_UNUSED;
    send_cmd(op, gear, 8'($urandom_range(0, 255)));
  endtask

  // Drop valid and wait until every result beat has come back
  task automatic wait_quiet();
    cmd_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (result_cnt != beats_sent) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] data);
    reg_ch.valid <= 1'b1;
    reg_ch.index <= idx;
    reg_ch.data  <= data;
    @(posedge clk_i);
    while (!reg_ch.ready) @(posedge clk_i);
    reg_writes++;
  endtask

  // Write the whole register set back to back, then release the channel
  task automatic program_regs(input logic [15:0] dly, input logic [15:0] pulse,
                              input logic [5:0] codes, input logic io_en,
                              input logic rev_fit);
    write_reg(CFG_DIR_DELAY, dly);
    write_reg(CFG_RESET_PULSE, pulse);
    write_reg(CFG_SPEED_CODES, {10'd0, codes});
    write_reg(CFG_SPEED_IO_EN, {15'd0, io_en});
    write_reg(CFG_REVERSE_FITTED, {15'd0, rev_fit});
    reg_ch.valid <= 1'b0;
    @(posedge clk_i);
    settings_used++;
  endtask

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin : result_sink
    int unsigned n;
    res_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_sink) begin
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        hold_sink = 1'b0;
        res_ch.ready <= 1'b1;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        n = $urandom_range(1, 5);
        repeat (n) @(posedge clk_i);
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b1;
      end
      @(posedge clk_i);
    end
  end

  initial begin : stimulus
    int unsigned phase;
    rst_ni = 1'b0;
    end_check = 1'b0;
    cmd_ch.valid        <= 1'b0;
    cmd_ch.opcode       <= OP_RUN;
    cmd_ch.gear_request <= '0;
    cmd_ch.elapsed_ms   <= '0;
    reg_ch.valid        <= 1'b0;
    reg_ch.index        <= CFG_DIR_DELAY;
    reg_ch.data         <= '0;
    src_gaps      = 1'b1;
    sink_stalls   = 1'b1;
    hold_sink     = 1'b0;
    beats_sent    = 0;
    reg_writes    = 0;
    settings_used = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: short delays so reversals and reset pulses finish in a few ticks
    program_regs(16'd10, 16'd5, SPEED_CODES_RESET, 1'b1, 1'b1);
    send_cmd(OP_RUN, 1, 8'd0);
    send_cmd(OP_RUN, 3, 8'd0);
    send_cmd(OP_RUN, 2, 8'd0);
    send_cmd(OP_RUN, -2, 8'd0);          // reversal while running: gear waits
    send_cmd(OP_RUN, -3, 8'd0);          // same direction: swap waiting gear
    send_cmd(OP_TICK, 0, 8'd4);
    send_cmd(OP_RUN, 1, 8'd0);           // opposite request cancels the wait
    send_cmd(OP_RUN, -1, 8'd0);
    send_cmd(OP_TICK, 0, 8'd255);        // delay elapsed: reverse engages
    send_cmd(OP_RUN, 4, 8'd0);
    send_cmd(OP_RUN, -4, 8'd0);
    send_cmd(OP_RUN, 15, 8'd0);
    send_cmd(OP_RUN, -16, 8'd0);
    send_cmd(OP_FAULT_RESET, 0, 8'd0);
    send_cmd(OP_TICK, 0, 8'd2);
    send_cmd(OP_TICK, 0, 8'd3);          // pulse length reached
    send_cmd(OP_UNUSED, 15, 8'd255);
    send_cmd(OP_TICK, 0, 8'd0);
    send_cmd(OP_RUN, -3, 8'd0);
    // No reverse pin: reverse level masked, negative gears refused
    wait_quiet();
    program_regs(16'd10, 16'd5, SPEED_CODES_RESET, 1'b1, 1'b0);
    send_cmd(OP_RUN, -2, 8'd0);
    send_cmd(OP_RUN, -5, 8'd0);          // range test wins over missing reverse
    send_cmd(OP_RUN, 2, 8'd0);
    send_cmd(OP_TICK, 0, 8'd255);
    send_cmd(OP_RUN, 0, 8'd0);

    // Zero delays, zero pulse and empty speed codes
    wait_quiet();
    program_regs(16'd0, 16'd0, 6'd0, 1'b1, 1'b1);
    repeat (PHASE_BEATS) send_random_cmd();

    // Full-scale delays: run both timers into saturation
    wait_quiet();
    program_regs(16'hFFFF, 16'hFFFF, 6'h3F, 1'b1, 1'b1);
    send_cmd(OP_FAULT_RESET, 0, 8'd0);
    send_cmd(OP_RUN, 1, 8'd0);
    send_cmd(OP_RUN, -1, 8'd0);
    repeat (SAT_TICKS) send_cmd(OP_TICK, int'($urandom_range(0, 31)) - 16,
                                8'($urandom_range(252, 255)));

    // Random settings; state carries over between them
    for (phase = 0; phase < 4; phase++) begin
      wait_quiet();
      program_regs(16'($urandom_range(0, 700)), 16'($urandom_range(0, 400)),
                   6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      if (phase == 1) begin
        // Back up the result queue until the command side stalls
        src_gaps = 1'b0;
        hold_sink = 1'b1;
        repeat (12) send_random_cmd();
        wait_quiet();
      end
      src_gaps = (phase != 2);
      repeat (PHASE_BEATS) send_random_cmd();
      src_gaps = 1'b1;
    end

    // Closing stretch at full rate on both sides
    wait_quiet();
    program_regs(16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                 6'($urandom_range(0, 63)), 1'b1, 1'b1);
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    repeat (50) send_random_cmd();

    wait_quiet();
    repeat (10) @(posedge clk_i);
    end_check <= 1'b1;
    repeat (3) @(posedge clk_i);
    $display("Drove %0d command beats and %0d register writes across %0d settings,",
             beats_sent, reg_writes, settings_used);
    $display("covering reversals, fault pulses, timer saturation and a backed-up queue.");
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin : run_limit
    #200_000;
    $display("Run timed out");
    $display("Verification failed");
    $finish;
  end

endmodule
